// ----- rtl/core/pss_pkg.sv -----
// pss_pkg: shared sizes, register indexes and fixed-point constants
// for the probe seek-and-sense step block
// no dependencies
package pss_pkg;

  localparam int MAX_BODIES = 256;
  localparam int ADDR_W     = (MAX_BODIES > 1) ? $clog2(MAX_BODIES) : 1;
  localparam int CNT_W      = $clog2(MAX_BODIES + 1);

  // body entry: {kind, mass, y, x}
  localparam int ENTRY_W = 104;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_SENSE_RADIUS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INV_AREA     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BODY_COUNT   = 2'd2;

  localparam logic [31:0] RESET_SENSE_RADIUS = 32'd65536;
  localparam logic [31:0] RESET_INV_AREA     = 32'd20861;

  // accumulators of the seek walk
  localparam int MSUM_W = 32 + CNT_W;
  localparam int SUM_W  = 48 + CNT_W;

  // restoring divider widths, shared by the mean and speed divides
  localparam int DIV_N_W   = (SUM_W + 16 > 51) ? SUM_W + 16 : 51;
  localparam int DIV_D_W   = (MSUM_W > 33) ? MSUM_W : 33;
  localparam int DIV_CNT_W = $clog2(DIV_N_W + 1);

  // digit-by-digit square root
  localparam int SQ_IN_W   = 66;
  localparam int SQ_ROOT_W = 33;
  localparam int SQ_REM_W  = 35;
  localparam int SQ_CNT_W  = 6;

  // Q16.16 constants
  localparam logic signed [17:0] K_SEEK     = 18'sd39322;
  localparam logic signed [17:0] K_HOME_NEG = -18'sd6554;
  localparam logic signed [17:0] K_CONF     = 18'sd3277;
  localparam logic [15:0]        K_DAMP     = 16'd58982;
  localparam logic [17:0]        K_VMAX     = 18'd196608;
  localparam logic [63:0]        VMAX_SQ    = 64'd38654705664;

endpackage

// ----- rtl/core/pss_ram.sv -----
// pss_ram: generic single-port-write, registered-read RAM
// no dependencies
module pss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/core/pss_div.sv -----
// pss_div: unsigned restoring divider, one quotient bit per cycle
// depends on pss_pkg for operand widths
module pss_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [pss_pkg::DIV_N_W-1:0] dividend,
  input  logic [pss_pkg::DIV_D_W-1:0] divisor,
  output logic                        done,
  output logic [pss_pkg::DIV_N_W-1:0] quotient
);

  logic [pss_pkg::DIV_N_W-1:0]   num_r, num_nxt;
  logic [pss_pkg::DIV_D_W-1:0]   den_r, den_nxt;
  logic [pss_pkg::DIV_D_W-1:0]   rem_r, rem_nxt;
  logic [pss_pkg::DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                          run_r, run_nxt;
  logic                          done_r, done_nxt;
  logic [pss_pkg::DIV_D_W:0]     sh;
  logic                          ge;

  always_comb begin
    sh       = {rem_r, num_r[pss_pkg::DIV_N_W-1]};
    ge       = (sh >= {1'b0, den_r});
    num_nxt  = num_r;
    den_nxt  = den_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (start) begin
      num_nxt = dividend;
      den_nxt = divisor;
      rem_nxt = '0;
      cnt_nxt = pss_pkg::DIV_CNT_W'(pss_pkg::DIV_N_W);
      run_nxt = 1'b1;
    end else if (run_r) begin
      num_nxt = {num_r[pss_pkg::DIV_N_W-2:0], ge};
      rem_nxt = ge ? pss_pkg::DIV_D_W'(sh - {1'b0, den_r}) : sh[pss_pkg::DIV_D_W-1:0];
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == pss_pkg::DIV_CNT_W'(1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    num_r <= num_nxt;
    den_r <= den_nxt;
    rem_r <= rem_nxt;
    cnt_r <= cnt_nxt;
  end

  assign done     = done_r;
  assign quotient = num_r;

endmodule

// ----- rtl/core/pss_sqrt.sv -----
// pss_sqrt: floor square root, two radicand bits per cycle, with remainder
// depends on pss_pkg for widths
module pss_sqrt (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [pss_pkg::SQ_IN_W-1:0]   radicand,
  output logic                          done,
  output logic [pss_pkg::SQ_ROOT_W-1:0] root,
  output logic [pss_pkg::SQ_REM_W-1:0]  remainder
);

  logic [pss_pkg::SQ_IN_W-1:0]   rad_r, rad_nxt;
  logic [pss_pkg::SQ_ROOT_W-1:0] root_r, root_nxt;
  logic [pss_pkg::SQ_REM_W-1:0]  rem_r, rem_nxt;
  logic [pss_pkg::SQ_CNT_W-1:0]  cnt_r, cnt_nxt;
  logic                          run_r, run_nxt;
  logic                          done_r, done_nxt;
  logic [pss_pkg::SQ_REM_W+1:0]  sh;
  logic [pss_pkg::SQ_REM_W+1:0]  trial;
  logic                          ge;

  always_comb begin
    sh       = {rem_r, rad_r[pss_pkg::SQ_IN_W-1 -: 2]};
    trial    = (pss_pkg::SQ_REM_W + 2)'({root_r, 2'b01});
    ge       = (sh >= trial);
    rad_nxt  = rad_r;
    root_nxt = root_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (start) begin
      rad_nxt  = radicand;
      root_nxt = '0;
      rem_nxt  = '0;
      cnt_nxt  = pss_pkg::SQ_CNT_W'(pss_pkg::SQ_ROOT_W);
      run_nxt  = 1'b1;
    end else if (run_r) begin
      rad_nxt  = {rad_r[pss_pkg::SQ_IN_W-3:0], 2'b00};
      root_nxt = {root_r[pss_pkg::SQ_ROOT_W-2:0], ge};
      rem_nxt  = ge ? pss_pkg::SQ_REM_W'(sh - trial) : sh[pss_pkg::SQ_REM_W-1:0];
      cnt_nxt  = cnt_r - 1'b1;
      if (cnt_r == pss_pkg::SQ_CNT_W'(1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rad_r  <= rad_nxt;
    root_r <= root_nxt;
    rem_r  <= rem_nxt;
    cnt_r  <= cnt_nxt;
  end

  assign done      = done_r;
  assign root      = root_r;
  assign remainder = rem_r;

endmodule

// ----- rtl/core/probe_seek_and_sense_step.sv -----
// probe_seek_and_sense_step: body table plus probe steer, move and sense sequencer
// depends on pss_pkg, pss_ram, pss_div and pss_sqrt
//
// channel  ports                       handshake
// input    in_* fields                 start high while busy low
// result   out_* fields                out_valid high for one cycle
// config   cfg_we, cfg_index, cfg_data write when cfg_we high, no wait
//
// a body load never raises busy. a step keeps busy high for its n walked bodies,
// plus the mean divides when the seek set holds mass, a root and the speed divides
// when the speed limit engages and a root each time the sensing walk finds a new
// nearest body; each body passes read, data, square, sum and check states on the
// single table read port, the mean and speed divides run one bit a cycle and every
// root goes through the one shared unit. reset restores control and configuration
// defaults only; the table is undefined until loaded. results cannot be stalled.
module probe_seek_and_sense_step (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_mode,
  input  logic [7:0]                    in_body_index,
  input  logic signed [31:0]            in_body_x,
  input  logic signed [31:0]            in_body_y,
  input  logic [31:0]                   in_body_mass,
  input  logic [7:0]                    in_body_kind,
  input  logic signed [31:0]            in_probe_x,
  input  logic signed [31:0]            in_probe_y,
  input  logic signed [31:0]            in_probe_vx,
  input  logic signed [31:0]            in_probe_vy,
  input  logic [15:0]                   in_time_step,
  output logic                          out_valid,
  output logic signed [31:0]            out_new_x,
  output logic signed [31:0]            out_new_y,
  output logic signed [31:0]            out_new_vx,
  output logic signed [31:0]            out_new_vy,
  output logic [31:0]                   out_density,
  output logic [7:0]                    out_nearest_kind,
  output logic [31:0]                   out_nearest_distance,
  output logic                          out_nearest_valid,
  input  logic                          cfg_we,
  input  logic [pss_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_data
);

  typedef enum logic [18:0] {
    ST_IDLE  = 19'h00001,
    ST_PREP  = 19'h00002,
    ST_RD    = 19'h00004,
    ST_DAT   = 19'h00008,
    ST_SQR   = 19'h00010,
    ST_SUM   = 19'h00020,
    ST_CHK   = 19'h00040,
    ST_ROOT  = 19'h00080,
    ST_DIVGO = 19'h00100,
    ST_MEAN  = 19'h00200,
    ST_STEER = 19'h00400,
    ST_KICK  = 19'h00800,
    ST_DAMP  = 19'h01000,
    ST_SPEED = 19'h02000,
    ST_CHKV  = 19'h04000,
    ST_VROOT = 19'h08000,
    ST_LIM   = 19'h10000,
    ST_MOVE  = 19'h20000,
    ST_OUT   = 19'h40000
  } state_t;

  localparam int AW  = pss_pkg::ADDR_W;
  localparam int CW  = pss_pkg::CNT_W;
  localparam int SW  = pss_pkg::SUM_W;
  localparam int MW  = pss_pkg::MSUM_W;
  localparam int NW  = pss_pkg::DIV_N_W;
  localparam int DW  = pss_pkg::DIV_D_W;
  localparam int QW  = pss_pkg::SQ_IN_W;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] res;
    if (v > 64'sd2147483647) begin
      res = 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      res = 32'sh80000000;
    end else begin
      res = v[31:0];
    end
    return res;
  endfunction

  state_t state_r, state_nxt;

  // configuration
  logic [31:0] radius_r, radius_nxt;
  logic [31:0] inv_area_r, inv_area_nxt;
  logic [8:0]  body_count_r, body_count_nxt;

  // probe
  logic signed [31:0] px_r, px_nxt, py_r, py_nxt;
  logic signed [31:0] vx_r, vx_nxt, vy_r, vy_nxt;
  logic signed [31:0] sx_r, sx_nxt, sy_r, sy_nxt;
  logic signed [31:0] mx_r, mx_nxt, my_r, my_nxt;
  logic [15:0]        dt_r, dt_nxt;
  logic [16:0]        f_r, f_nxt;
  logic [63:0]        v2_r, v2_nxt;

  // walk
  logic [CW-1:0]      n_r, n_nxt, i_r, i_nxt;
  logic               pass2_r, pass2_nxt;
  logic [63:0]        r2_r, r2_nxt;
  logic [QW-1:0]      w2_r, w2_nxt;
  logic [31:0]        ux_r, ux_nxt, uy_r, uy_nxt;
  logic signed [31:0] ex_r, ex_nxt, ey_r, ey_nxt;
  logic [31:0]        em_r, em_nxt;
  logic [7:0]         ek_r, ek_nxt;
  logic [63:0]        sqx_r, sqx_nxt, sqy_r, sqy_nxt;
  logic signed [47:0] xm_r, xm_nxt, ym_r, ym_nxt;
  logic [QW-1:0]      s_r, s_nxt;

  // accumulators
  logic signed [SW-1:0] sumx_r, sumx_nxt, sumy_r, sumy_nxt;
  logic [MW-1:0]        msum_r, msum_nxt;
  logic [CW-1:0]        count_r, count_nxt;
  logic                 best_valid_r, best_valid_nxt;
  logic [32:0]          best_d_r, best_d_nxt;
  logic [QW-1:0]        best_d2_r, best_d2_nxt;
  logic [7:0]           best_kind_r, best_kind_nxt;

  // results
  logic        out_valid_r, out_valid_nxt;
  logic [31:0] dens_r, dens_nxt;
  logic [7:0]  nkind_r, nkind_nxt;
  logic [31:0] ndist_r, ndist_nxt;
  logic        nvalid_r, nvalid_nxt;

  // table
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [pss_pkg::ENTRY_W-1:0] ram_wdata, ram_rdata;
  logic signed [31:0] rd_x, rd_y;

  // shared units
  logic              div_start, div_done_x, div_done_y;
  logic [NW-1:0]     div_num_x, div_num_y, div_q_x, div_q_y;
  logic [DW-1:0]     div_den;
  logic              sq_start, sq_done;
  logic [QW-1:0]     sq_rad;
  logic [pss_pkg::SQ_ROOT_W-1:0] sq_root;
  logic [pss_pkg::SQ_REM_W-1:0]  sq_rem;

  // datapath temporaries
  logic signed [32:0] dx_c, dy_c;
  logic [32:0]        w_c;
  logic [63:0]        wl2_c;
  logic               has_mass, last, adv, take;
  logic [SW-1:0]      magx_c, magy_c;
  logic signed [32:0] dmx_c, dmy_c;
  logic signed [50:0] pax_c, pay_c, pbx_c, pby_c, pcx_c, pcy_c;
  logic signed [63:0] stx_c, sty_c;
  logic [32:0]        mvx_c, mvy_c;
  logic [50:0]        lmx_c, lmy_c;
  logic [CW+31:0]     dens_c;
  logic               in_range;

  assign rd_x = ram_rdata[31:0];
  assign rd_y = ram_rdata[63:32];

  assign in_range  = (32'(in_body_index) < pss_pkg::MAX_BODIES);
  assign ram_we    = start && !busy && !in_mode && in_range;
  assign ram_waddr = AW'(in_body_index);
  assign ram_wdata = {in_body_kind, in_body_mass, in_body_y, in_body_x};

  pss_ram #(.WIDTH(pss_pkg::ENTRY_W), .DEPTH(pss_pkg::MAX_BODIES)) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (i_r[AW-1:0]),
    .rdata (ram_rdata)
  );

  pss_div u_div_x (
    .clk (clk), .rst_n (rst_n), .start (div_start),
    .dividend (div_num_x), .divisor (div_den),
    .done (div_done_x), .quotient (div_q_x)
  );

  pss_div u_div_y (
    .clk (clk), .rst_n (rst_n), .start (div_start),
    .dividend (div_num_y), .divisor (div_den),
    .done (div_done_y), .quotient (div_q_y)
  );

  pss_sqrt u_sqrt (
    .clk (clk), .rst_n (rst_n), .start (sq_start),
    .radicand (sq_rad), .done (sq_done),
    .root (sq_root), .remainder (sq_rem)
  );

  // operand selection for the shared units
  always_comb begin
    has_mass = (msum_r != '0);
    magx_c = sumx_r[SW-1] ? SW'(-sumx_r) : SW'(sumx_r);
    magy_c = sumy_r[SW-1] ? SW'(-sumy_r) : SW'(sumy_r);
    mvx_c  = vx_r[31] ? 33'(-{vx_r[31], vx_r}) : {1'b0, vx_r};
    mvy_c  = vy_r[31] ? 33'(-{vy_r[31], vy_r}) : {1'b0, vy_r};
    lmx_c  = 51'(mvx_c) * 51'(pss_pkg::K_VMAX);
    lmy_c  = 51'(mvy_c) * 51'(pss_pkg::K_VMAX);
    if (state_r == ST_VROOT) begin
      div_num_x = NW'(lmx_c);
      div_num_y = NW'(lmy_c);
      div_den   = DW'(sq_root);
    end else begin
      div_num_x = NW'({magx_c, 16'b0});
      div_num_y = NW'({magy_c, 16'b0});
      div_den   = DW'(msum_r);
    end
    div_start = ((state_r == ST_DIVGO) && has_mass) || ((state_r == ST_VROOT) && sq_done);
    sq_rad    = (state_r == ST_CHK) ? s_r : QW'(v2_r);
  end

  always_comb begin
    state_nxt      = state_r;
    radius_nxt     = radius_r;
    inv_area_nxt   = inv_area_r;
    body_count_nxt = body_count_r;
    px_nxt = px_r;  py_nxt = py_r;  vx_nxt = vx_r;  vy_nxt = vy_r;
    sx_nxt = sx_r;  sy_nxt = sy_r;  mx_nxt = mx_r;  my_nxt = my_r;
    dt_nxt = dt_r;  f_nxt = f_r;    v2_nxt = v2_r;
    n_nxt = n_r;    i_nxt = i_r;    pass2_nxt = pass2_r;
    r2_nxt = r2_r;  w2_nxt = w2_r;
    ux_nxt = ux_r;  uy_nxt = uy_r;  ex_nxt = ex_r;  ey_nxt = ey_r;
    em_nxt = em_r;  ek_nxt = ek_r;
    sqx_nxt = sqx_r; sqy_nxt = sqy_r; xm_nxt = xm_r; ym_nxt = ym_r; s_nxt = s_r;
    sumx_nxt = sumx_r; sumy_nxt = sumy_r; msum_nxt = msum_r; count_nxt = count_r;
    best_valid_nxt = best_valid_r; best_d_nxt = best_d_r;
    best_d2_nxt = best_d2_r; best_kind_nxt = best_kind_r;
    out_valid_nxt = 1'b0;
    dens_nxt = dens_r; nkind_nxt = nkind_r; ndist_nxt = ndist_r; nvalid_nxt = nvalid_r;
    sq_start = 1'b0;
    adv  = 1'b0;
    take = 1'b0;
    last = ((i_r + CW'(1)) == n_r);

    dx_c  = {rd_x[31], rd_x} - {px_r[31], px_r};
    dy_c  = {rd_y[31], rd_y} - {py_r[31], py_r};
    w_c   = {1'b0, radius_r} + {2'b0, radius_r[31:1]};
    wl2_c = w_c[31:0] * w_c[31:0];
    dmx_c = {mx_r[31], mx_r} - {px_r[31], px_r};
    dmy_c = {my_r[31], my_r} - {py_r[31], py_r};
    pax_c = dmx_c * pss_pkg::K_SEEK;
    pay_c = dmy_c * pss_pkg::K_SEEK;
    pbx_c = px_r * pss_pkg::K_HOME_NEG;
    pby_c = py_r * pss_pkg::K_HOME_NEG;
    pcx_c = px_r * pss_pkg::K_CONF;
    pcy_c = py_r * pss_pkg::K_CONF;
    stx_c = (has_mass ? (pax_c >>> 16) : (pbx_c >>> 16)) - (pcx_c >>> 16);
    sty_c = (has_mass ? (pay_c >>> 16) : (pby_c >>> 16)) - (pcy_c >>> 16);
    dens_c = (CW + 32)'(count_r) * (CW + 32)'(inv_area_r);

    if (cfg_we) begin
      case (cfg_index)
        pss_pkg::REG_SENSE_RADIUS: radius_nxt     = cfg_data;
        pss_pkg::REG_INV_AREA:     inv_area_nxt   = cfg_data;
        pss_pkg::REG_BODY_COUNT:   body_count_nxt = cfg_data[8:0];
        default: ;
      endcase
    end

    unique case (state_r)
      ST_IDLE: begin
        if (start && in_mode) begin
          px_nxt = in_probe_x;  py_nxt = in_probe_y;
          vx_nxt = in_probe_vx; vy_nxt = in_probe_vy;
          dt_nxt = in_time_step;
          n_nxt  = (32'(body_count_r) < pss_pkg::MAX_BODIES) ? CW'(body_count_r)
                                                             : CW'(pss_pkg::MAX_BODIES);
          i_nxt = '0;
          pass2_nxt = 1'b0;
          sumx_nxt = '0; sumy_nxt = '0; msum_nxt = '0; count_nxt = '0;
          best_valid_nxt = 1'b0;
          state_nxt = ST_PREP;
        end
      end
      ST_PREP: begin
        r2_nxt = radius_r * radius_r;
        w2_nxt = {2'b0, wl2_c} + (w_c[32] ? ({1'b0, w_c[31:0], 33'b0} + {2'b01, 64'b0}) : '0);
        f_nxt  = 17'(18'd65536 - 18'(({16'b0, pss_pkg::K_DAMP} * {16'b0, dt_r}) >> 16));
        state_nxt = (n_r == '0) ? ST_DIVGO : ST_RD;
      end
      ST_RD: state_nxt = ST_DAT;
      ST_DAT: begin
        ux_nxt = dx_c[32] ? 32'(-dx_c) : dx_c[31:0];
        uy_nxt = dy_c[32] ? 32'(-dy_c) : dy_c[31:0];
        ex_nxt = rd_x;
        ey_nxt = rd_y;
        em_nxt = ram_rdata[95:64];
        ek_nxt = ram_rdata[103:96];
        state_nxt = ST_SQR;
      end
      ST_SQR: begin
        sqx_nxt = ux_r * ux_r;
        sqy_nxt = uy_r * uy_r;
        xm_nxt  = 48'((65'(ex_r) * $signed({33'b0, em_r})) >>> 16);
        ym_nxt  = 48'((65'(ey_r) * $signed({33'b0, em_r})) >>> 16);
        state_nxt = ST_SUM;
      end
      ST_SUM: begin
        s_nxt = {2'b0, sqx_r} + {2'b0, sqy_r};
        state_nxt = ST_CHK;
      end
      ST_CHK: begin
        if (!pass2_r) begin
          // seek set: distance below 1.5 radii
          if (s_r < w2_r) begin
            sumx_nxt = sumx_r + SW'(xm_r);
            sumy_nxt = sumy_r + SW'(ym_r);
            msum_nxt = msum_r + MW'(em_r);
          end
          adv = 1'b1;
        end else begin
          if (s_r < {2'b0, r2_r}) begin
            count_nxt = count_r + CW'(1);
          end
          // strictly nearer than the floored best distance
          take = !best_valid_r || (s_r < best_d2_r);
          if (take) begin
            sq_start  = 1'b1;
            state_nxt = ST_ROOT;
          end else begin
            adv = 1'b1;
          end
        end
      end
      ST_ROOT: begin
        if (sq_done) begin
          best_valid_nxt = 1'b1;
          best_d_nxt     = sq_root;
          best_d2_nxt    = s_r - QW'(sq_rem);
          best_kind_nxt  = ek_r;
          adv = 1'b1;
        end
      end
      ST_DIVGO: state_nxt = has_mass ? ST_MEAN : ST_STEER;
      ST_MEAN: begin
        if (div_done_x && div_done_y) begin
          if (!sumx_r[SW-1]) begin
            mx_nxt = (div_q_x > NW'(32'h7fffffff)) ? 32'sh7fffffff : div_q_x[31:0];
          end else begin
            mx_nxt = (div_q_x > NW'(33'h080000000)) ? 32'sh80000000 : -div_q_x[31:0];
          end
          if (!sumy_r[SW-1]) begin
            my_nxt = (div_q_y > NW'(32'h7fffffff)) ? 32'sh7fffffff : div_q_y[31:0];
          end else begin
            my_nxt = (div_q_y > NW'(33'h080000000)) ? 32'sh80000000 : -div_q_y[31:0];
          end
          state_nxt = ST_STEER;
        end
      end
      ST_STEER: begin
        sx_nxt = sat32(stx_c);
        sy_nxt = sat32(sty_c);
        state_nxt = ST_KICK;
      end
      ST_KICK: begin
        vx_nxt = sat32(64'(vx_r) + ((64'(sx_r) * $signed({48'b0, dt_r})) >>> 16));
        vy_nxt = sat32(64'(vy_r) + ((64'(sy_r) * $signed({48'b0, dt_r})) >>> 16));
        state_nxt = ST_DAMP;
      end
      ST_DAMP: begin
        vx_nxt = 32'((64'(vx_r) * $signed({47'b0, f_r})) >>> 16);
        vy_nxt = 32'((64'(vy_r) * $signed({47'b0, f_r})) >>> 16);
        state_nxt = ST_SPEED;
      end
      ST_SPEED: begin
        v2_nxt = 64'(64'(vx_r) * 64'(vx_r) + 64'(vy_r) * 64'(vy_r));
        state_nxt = ST_CHKV;
      end
      ST_CHKV: begin
        if (v2_r > pss_pkg::VMAX_SQ) begin
          sq_start  = 1'b1;
          state_nxt = ST_VROOT;
        end else begin
          state_nxt = ST_MOVE;
        end
      end
      ST_VROOT: begin
        if (sq_done) begin
          state_nxt = ST_LIM;
        end
      end
      ST_LIM: begin
        if (div_done_x && div_done_y) begin
          vx_nxt = vx_r[31] ? -div_q_x[31:0] : div_q_x[31:0];
          vy_nxt = vy_r[31] ? -div_q_y[31:0] : div_q_y[31:0];
          state_nxt = ST_MOVE;
        end
      end
      ST_MOVE: begin
        px_nxt = sat32(64'(px_r) + ((64'(vx_r) * $signed({48'b0, dt_r})) >>> 16));
        py_nxt = sat32(64'(py_r) + ((64'(vy_r) * $signed({48'b0, dt_r})) >>> 16));
        i_nxt     = '0;
        pass2_nxt = 1'b1;
        state_nxt = (n_r == '0) ? ST_OUT : ST_RD;
      end
      ST_OUT: begin
        dens_nxt   = (|dens_c[CW+31:32]) ? 32'hffffffff : dens_c[31:0];
        nvalid_nxt = best_valid_r;
        nkind_nxt  = best_valid_r ? best_kind_r : 8'd0;
        ndist_nxt  = !best_valid_r ? 32'd0 :
                     (best_d_r[32] ? 32'hffffffff : best_d_r[31:0]);
        out_valid_nxt = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase

    // step to the next body or close the walk
    if (adv) begin
      if (last) begin
        state_nxt = pass2_r ? ST_OUT : ST_DIVGO;
      end else begin
        i_nxt     = i_r + CW'(1);
        state_nxt = ST_RD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_valid_r  <= 1'b0;
      radius_r     <= pss_pkg::RESET_SENSE_RADIUS;
      inv_area_r   <= pss_pkg::RESET_INV_AREA;
      body_count_r <= '0;
    end else begin
      state_r      <= state_nxt;
      out_valid_r  <= out_valid_nxt;
      radius_r     <= radius_nxt;
      inv_area_r   <= inv_area_nxt;
      body_count_r <= body_count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    px_r <= px_nxt;  py_r <= py_nxt;  vx_r <= vx_nxt;  vy_r <= vy_nxt;
    sx_r <= sx_nxt;  sy_r <= sy_nxt;  mx_r <= mx_nxt;  my_r <= my_nxt;
    dt_r <= dt_nxt;  f_r <= f_nxt;    v2_r <= v2_nxt;
    n_r <= n_nxt;    i_r <= i_nxt;    pass2_r <= pass2_nxt;
    r2_r <= r2_nxt;  w2_r <= w2_nxt;
    ux_r <= ux_nxt;  uy_r <= uy_nxt;  ex_r <= ex_nxt;  ey_r <= ey_nxt;
    em_r <= em_nxt;  ek_r <= ek_nxt;
    sqx_r <= sqx_nxt; sqy_r <= sqy_nxt; xm_r <= xm_nxt; ym_r <= ym_nxt; s_r <= s_nxt;
    sumx_r <= sumx_nxt; sumy_r <= sumy_nxt; msum_r <= msum_nxt; count_r <= count_nxt;
    best_valid_r <= best_valid_nxt; best_d_r <= best_d_nxt;
    best_d2_r <= best_d2_nxt; best_kind_r <= best_kind_nxt;
    dens_r <= dens_nxt; nkind_r <= nkind_nxt; ndist_r <= ndist_nxt; nvalid_r <= nvalid_nxt;
  end

  assign busy                 = (state_r != ST_IDLE);
  assign out_valid            = out_valid_r;
  assign out_new_x            = px_r;
  assign out_new_y            = py_r;
  assign out_new_vx           = vx_r;
  assign out_new_vy           = vy_r;
  assign out_density          = dens_r;
  assign out_nearest_kind     = nkind_r;
  assign out_nearest_distance = ndist_r;
  assign out_nearest_valid    = nvalid_r;

endmodule

// ----- bench/probe_step_checker.sv -----
// probe_step_checker: watches the load, step, result and register channels of
// probe_seek_and_sense_step, predicts each step result and compares it field by field
// depends on pss_pkg for the register index codes and the table depth
module probe_step_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic                          busy,
  input  logic                          in_mode,
  input  logic [7:0]                    in_body_index,
  input  logic signed [31:0]            in_body_x,
  input  logic signed [31:0]            in_body_y,
  input  logic [31:0]                   in_body_mass,
  input  logic [7:0]                    in_body_kind,
  input  logic signed [31:0]            in_probe_x,
  input  logic signed [31:0]            in_probe_y,
  input  logic signed [31:0]            in_probe_vx,
  input  logic signed [31:0]            in_probe_vy,
  input  logic [15:0]                   in_time_step,
  input  logic                          out_valid,
  input  logic signed [31:0]            out_new_x,
  input  logic signed [31:0]            out_new_y,
  input  logic signed [31:0]            out_new_vx,
  input  logic signed [31:0]            out_new_vy,
  input  logic [31:0]                   out_density,
  input  logic [7:0]                    out_nearest_kind,
  input  logic [31:0]                   out_nearest_distance,
  input  logic                          out_nearest_valid,
  input  logic                          cfg_we,
  input  logic [pss_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_data,
  output int                            errors,
  output int                            pending
);

  localparam int     TABLE_DEPTH = pss_pkg::MAX_BODIES;
  localparam longint GAIN_SEEK   = 39322;
  localparam longint GAIN_HOME   = 6554;
  localparam longint GAIN_CONF   = 3277;
  localparam longint DAMP_RATE   = 58982;
  localparam longint SPEED_MAX   = 196608;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic [31:0]        density;
    logic [7:0]         kind;
    logic [31:0]        near_dist;
    logic               valid;
  } step_result_t;

  logic signed [31:0] tab_x    [TABLE_DEPTH];
  logic signed [31:0] tab_y    [TABLE_DEPTH];
  logic [31:0]        tab_mass [TABLE_DEPTH];
  logic [7:0]         tab_kind [TABLE_DEPTH];
  logic [31:0]        radius;
  logic [31:0]        inv_area;
  logic [8:0]         walk_count;
  step_result_t       pending_steps[$];
  int                 mismatches = 0;

  assign errors  = mismatches;
  assign pending = pending_steps.size();

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic logic [32:0] root_floor(logic [65:0] v);
    logic [32:0] res;
    logic [32:0] t;
    logic [65:0] sq;
    res = '0;
    for (int b = 32; b >= 0; b--) begin
      t  = res | (33'd1 << b);
      sq = {33'd0, t} * {33'd0, t};
      if (sq <= v) res = t;
    end
    return res;
  endfunction

  function automatic logic [32:0] body_distance(int i, longint px, longint py);
    longint      dx;
    longint      dy;
    logic [65:0] ax;
    logic [65:0] ay;
    dx = longint'(tab_x[i]) - px;
    dy = longint'(tab_y[i]) - py;
    ax = (dx < 0) ? -dx : dx;
    ay = (dy < 0) ? -dy : dy;
    return root_floor(ax * ax + ay * ay);
  endfunction

  // quotient in Q16.16, truncated toward zero
  function automatic longint mass_centre(longint sum, longint mass);
    longint mag;
    longint q0;
    longint rem;
    longint q;
    mag = (sum < 0) ? -sum : sum;
    q0  = mag / mass;
    rem = mag % mass;
    q   = (q0 << 16) + ((rem << 16) / mass);
    return clamp32((sum < 0) ? -q : q);
  endfunction

  function automatic step_result_t predict_probe_step(longint px, longint py, longint vx,
                                                      longint vy, longint dt);
    step_result_t r;
    int           n;
    int           best_i;
    logic [33:0]  wide;
    logic [32:0]  d;
    logic [32:0]  best;
    longint       sumx;
    longint       sumy;
    longint       mass;
    longint       sx;
    longint       sy;
    longint       f;
    longint       sp;
    longint       count;
    logic [63:0]  v2;
    logic [63:0]  dens;
    n      = (walk_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(walk_count);
    wide   = {2'b0, radius} + {3'b0, radius[31:1]};
    sumx   = 0;
    sumy   = 0;
    mass   = 0;
    count  = 0;
    best   = '0;
    best_i = -1;
    for (int i = 0; i < n; i++) begin
      if ({1'b0, body_distance(i, px, py)} < wide) begin
        sumx += (longint'(tab_x[i]) * longint'(tab_mass[i])) >>> 16;
        sumy += (longint'(tab_y[i]) * longint'(tab_mass[i])) >>> 16;
        mass += longint'(tab_mass[i]);
      end
    end
    if (mass > 0) begin
      sx = ((mass_centre(sumx, mass) - px) * GAIN_SEEK) >>> 16;
      sy = ((mass_centre(sumy, mass) - py) * GAIN_SEEK) >>> 16;
    end else begin
      sx = (px * -GAIN_HOME) >>> 16;
      sy = (py * -GAIN_HOME) >>> 16;
    end
    sx = clamp32(sx - ((px * GAIN_CONF) >>> 16));
    sy = clamp32(sy - ((py * GAIN_CONF) >>> 16));
    vx = clamp32(vx + ((sx * dt) >>> 16));
    vy = clamp32(vy + ((sy * dt) >>> 16));
    f  = 65536 - ((DAMP_RATE * dt) >> 16);
    vx = (vx * f) >>> 16;
    vy = (vy * f) >>> 16;
    v2 = 64'(vx * vx) + 64'(vy * vy);
    if (v2 > 64'(SPEED_MAX * SPEED_MAX)) begin
      sp = longint'(root_floor({2'b0, v2}));
      vx = (vx * SPEED_MAX) / sp;
      vy = (vy * SPEED_MAX) / sp;
    end
    px = clamp32(px + ((vx * dt) >>> 16));
    py = clamp32(py + ((vy * dt) >>> 16));
    for (int i = 0; i < n; i++) begin
      d = body_distance(i, px, py);
      if (d < {1'b0, radius}) count++;
      if (best_i < 0 || d < best) begin
        best   = d;
        best_i = i;
      end
    end
    dens        = 64'(count) * 64'(inv_area);
    r.x         = px[31:0];
    r.y         = py[31:0];
    r.vx        = vx[31:0];
    r.vy        = vy[31:0];
    r.density   = (dens > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : dens[31:0];
    r.kind      = (best_i >= 0) ? tab_kind[best_i] : 8'd0;
    r.near_dist = (best_i < 0) ? 32'd0 : (best[32] ? 32'hFFFF_FFFF : best[31:0]);
    r.valid     = (best_i >= 0);
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch %s: expected %h got %h", name, want, got);
    end
  endtask

  always @(posedge clk) begin
    step_result_t want;
    if (!rst_n) begin
      radius     <= 32'd65536;
      inv_area   <= 32'd20861;
      walk_count <= '0;
      pending_steps.delete();
    end else begin
      if (out_valid) begin
        if (pending_steps.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: result with no step outstanding");
        end else begin
          want = pending_steps.pop_front();
          check_field("new_x", want.x, out_new_x);
          check_field("new_y", want.y, out_new_y);
          check_field("new_vx", want.vx, out_new_vx);
          check_field("new_vy", want.vy, out_new_vy);
          check_field("density", want.density, out_density);
          check_field("nearest_kind", 32'(want.kind), 32'(out_nearest_kind));
          check_field("nearest_distance", want.near_dist, out_nearest_distance);
          check_field("nearest_valid", 32'(want.valid), 32'(out_nearest_valid));
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          pss_pkg::REG_SENSE_RADIUS: radius     <= cfg_data;
          pss_pkg::REG_INV_AREA:     inv_area   <= cfg_data;
          pss_pkg::REG_BODY_COUNT:   walk_count <= cfg_data[8:0];
          default: ;
        endcase
      end
      if (start && !busy) begin
        if (!in_mode) begin
          tab_x[in_body_index]    = in_body_x;
          tab_y[in_body_index]    = in_body_y;
          tab_mass[in_body_index] = in_body_mass;
          tab_kind[in_body_index] = in_body_kind;
        end else begin
          pending_steps.insert(pending_steps.size(),
                               predict_probe_step(longint'(in_probe_x), longint'(in_probe_y),
                                                  longint'(in_probe_vx), longint'(in_probe_vy),
                                                  longint'(in_time_step)));
        end
      end
    end
  end

endmodule

// ----- bench/tb_probe_seek_and_sense_step.sv -----
// tb_probe_seek_and_sense_step: stimulus and verdict for probe_seek_and_sense_step
// depends on pss_pkg, the block itself and probe_step_checker
module tb_probe_seek_and_sense_step;

  localparam int CYCLE_LIMIT = 10000000;
  localparam int ITEM_TARGET = 1150;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          start = 1'b0;
  logic                          busy;
  logic                          in_mode = 1'b0;
  logic [7:0]                    in_body_index = '0;
  logic signed [31:0]            in_body_x = '0;
  logic signed [31:0]            in_body_y = '0;
  logic [31:0]                   in_body_mass = '0;
  logic [7:0]                    in_body_kind = '0;
  logic signed [31:0]            in_probe_x = '0;
  logic signed [31:0]            in_probe_y = '0;
  logic signed [31:0]            in_probe_vx = '0;
  logic signed [31:0]            in_probe_vy = '0;
  logic [15:0]                   in_time_step = '0;
  logic                          out_valid;
  logic signed [31:0]            out_new_x;
  logic signed [31:0]            out_new_y;
  logic signed [31:0]            out_new_vx;
  logic signed [31:0]            out_new_vy;
  logic [31:0]                   out_density;
  logic [7:0]                    out_nearest_kind;
  logic [31:0]                   out_nearest_distance;
  logic                          out_nearest_valid;
  logic                          cfg_we = 1'b0;
  logic [pss_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0]                   cfg_data = '0;
  int                            errors;
  int                            pending;
  int                            cycles = 0;
  int                            items = 0;
  bit                            quiet = 1'b0;
  bit                            loaded [256];

  always #1 clk = ~clk;

  probe_seek_and_sense_step dut (.*);

  probe_step_checker u_checker (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_probe_seek_and_sense_step: errors");
      $finish;
    end
  end

  function automatic int filled_prefix();
    int p;
    p = 0;
    while (p < 256 && loaded[p]) p++;
    return p;
  endfunction

  // mostly within a few units of the origin so bodies and probes meet
  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 9))
      0:       return $urandom;
      1:       return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
    endcase
  endfunction

  function automatic logic [31:0] rand_mass();
    case ($urandom_range(0, 7))
      0:       return 32'd0;
      1:       return 32'hFFFF_FFFF;
      2:       return $urandom;
      default: return $urandom_range(0, 32'h0010_0000);
    endcase
  endfunction

  task automatic pause_after();
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // hold start until the block takes the transaction
  task automatic hand_over();
    start <= 1'b1;
    do @(posedge clk); while (busy);
    items++;
    pause_after();
  endtask

  task automatic load_body(logic [7:0] idx, logic [31:0] x, logic [31:0] y,
                           logic [31:0] m, logic [7:0] k);
    in_mode       <= 1'b0;
    in_body_index <= idx;
    in_body_x     <= x;
    in_body_y     <= y;
    in_body_mass  <= m;
    in_body_kind  <= k;
    in_probe_x    <= $urandom;
    in_probe_y    <= $urandom;
    in_probe_vx   <= $urandom;
    in_probe_vy   <= $urandom;
    in_time_step  <= $urandom;
    loaded[idx] = 1'b1;
    hand_over();
  endtask

  task automatic step_probe(logic [31:0] x, logic [31:0] y, logic [31:0] vx,
                            logic [31:0] vy, logic [15:0] dt);
    in_mode       <= 1'b1;
    in_body_index <= $urandom;
    in_body_x     <= $urandom;
    in_body_y     <= $urandom;
    in_body_mass  <= $urandom;
    in_body_kind  <= $urandom;
    in_probe_x    <= x;
    in_probe_y    <= y;
    in_probe_vx   <= vx;
    in_probe_vy   <= vy;
    in_time_step  <= dt;
    hand_over();
  endtask

  task automatic rand_step();
    step_probe(rand_coord(), rand_coord(), rand_coord(), rand_coord(), $urandom);
  endtask

  // drain outstanding steps, then idle a little
  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0 || busy) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [pss_pkg::CFG_IDX_W-1:0] idx, logic [31:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_walk(int n);
    write_reg(pss_pkg::REG_BODY_COUNT, ($urandom & ~32'h1FF) | 32'(n));
  endtask

  initial begin
    int p;
    int n;
    int steps;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty table: no nearest body, origin steering
    step_probe(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 16'hFFFF);
    step_probe(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 16'h0000);
    load_body(8'd0, 32'd0, 32'd0, 32'd0, 8'hFF);
    load_body(8'd1, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 8'h00);
    load_body(8'd2, 32'h0002_0000, 32'hFFFE_0000, 32'h0001_0000, 8'hAA);
    load_body(8'd3, 32'h0002_0000, 32'hFFFE_0000, 32'h5555_5555, 8'h55);
    settle();
    write_reg(pss_pkg::REG_SENSE_RADIUS, 32'hFFFF_FFFF);
    write_reg(pss_pkg::REG_INV_AREA, 32'hFFFF_FFFF);
    set_walk(4);
    step_probe(32'd0, 32'd0, 32'd0, 32'd0, 16'h8000);
    step_probe(32'h0002_0000, 32'hFFFE_0000, 32'h0004_0000, 32'h0004_0000, 16'hFFFF);
    step_probe(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'hFFFF);
    settle();
    // zero-mass body alone in range takes the origin path
    write_reg(pss_pkg::REG_SENSE_RADIUS, 32'h0004_0000);
    write_reg(pss_pkg::REG_INV_AREA, 32'd0);
    set_walk(1);
    step_probe(32'h0001_0000, 32'h0001_0000, 32'h0000_8000, 32'hFFFF_8000, 16'h4000);
    settle();
    write_reg(pss_pkg::REG_SENSE_RADIUS, 32'd0);
    write_reg(2'd3, $urandom);
    set_walk(4);
    step_probe(32'h0002_0000, 32'hFFFE_0000, 32'd0, 32'd0, 16'h1000);
    settle();

    while (items < ITEM_TARGET - 280) begin
      settle();
      quiet = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 5))
        0:       write_reg(pss_pkg::REG_SENSE_RADIUS, 32'd0);
        1:       write_reg(pss_pkg::REG_SENSE_RADIUS, 32'hFFFF_FFFF);
        2:       write_reg(pss_pkg::REG_SENSE_RADIUS, $urandom);
        default: write_reg(pss_pkg::REG_SENSE_RADIUS, $urandom_range(32'h4000, 32'h0008_0000));
      endcase
      case ($urandom_range(0, 3))
        0:       write_reg(pss_pkg::REG_INV_AREA, 32'd0);
        1:       write_reg(pss_pkg::REG_INV_AREA, 32'hFFFF_FFFF);
        default: write_reg(pss_pkg::REG_INV_AREA, $urandom);
      endcase
      repeat ($urandom_range(1, 6)) begin
        p = filled_prefix();
        load_body((p < 256 && $urandom_range(0, 2) != 0) ? 8'(p) : 8'($urandom),
                  rand_coord(), rand_coord(), rand_mass(), $urandom);
      end
      settle();
      p = filled_prefix();
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(0, (p < 32) ? p : 32)
                                       : $urandom_range(0, (p < 8) ? p : 8);
      set_walk(n);
      steps = $urandom_range(10, 30);
      repeat (steps) begin
        if ($urandom_range(0, 9) == 0)
          load_body($urandom, rand_coord(), rand_coord(), rand_mass(), $urandom);
        else
          rand_step();
      end
    end

    // full table, then a count past its end
    settle();
    quiet = 1'b0;
    for (int i = 0; i < 256; i++)
      load_body(8'(i), rand_coord(), rand_coord(), rand_mass(), $urandom);
    settle();
    write_reg(pss_pkg::REG_SENSE_RADIUS, $urandom_range(32'h0001_0000, 32'h0008_0000));
    set_walk(256);
    repeat (4) rand_step();
    settle();
    set_walk($urandom_range(257, 511));
    repeat (4) rand_step();

    settle();
    repeat (3000) @(posedge clk);
    if (errors == 0) begin
      $display("tb_probe_seek_and_sense_step: clean");
    end else begin
      $display("tb_probe_seek_and_sense_step: errors");
    end
    $finish;
  end

endmodule
